/* sv/gravity_tilt_angle_macros.svh */
// Assertion macros used by the tilt angle top-level RTL file.
`ifndef GRAVITY_TILT_ANGLE_MACROS_SVH
`define GRAVITY_TILT_ANGLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gta_pkg.sv */
// Package: types, constants and the arctangent table for the tilt angle block.
`timescale 1ns / 1ps
package gta_pkg;

  localparam int GTA_CORDIC_STEPS = 16;
  localparam int GTA_ATAN_ENTRIES = 24;

  localparam int XW = 36;  // CORDIC x/y width
  localparam int ZW = 33;  // CORDIC angle width, Q29 signed

  localparam logic signed [ZW-1:0] PI_Q29      = 33'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic [28:0] DEG128_MUL  = 29'd480631834;
  localparam logic [15:0] DEG128_HALF = 16'd23040;
  localparam logic [15:0] DEG128_FULL = 16'd46080;
  localparam logic [15:0] RAD13_HALF  = 16'd25736;
  localparam logic [15:0] RAD13_FULL  = 16'd51472;

  // Configuration register indexes
  localparam logic REG_OUT_DEG = 1'b0;
  localparam logic REG_REF_AXIS = 1'b1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic [15:0] angle;
    logic        zero_vector;
  } out_t;

  // Per-request sideband carried along the pipeline
  typedef struct packed {
    logic signed [16:0] u;
    logic               neg;
    logic               zero;
  } side_t;

  function automatic logic [ZW-1:0] atan_q29(input int i);
    logic [ZW-1:0] a;
    case (i)
      0:  a = 33'd421657428;
      1:  a = 33'd248918915;
      2:  a = 33'd131521918;
      3:  a = 33'd66762579;
      4:  a = 33'd33510843;
      5:  a = 33'd16771758;
      6:  a = 33'd8387925;
      7:  a = 33'd4194219;
      8:  a = 33'd2097141;
      9:  a = 33'd1048575;
      10: a = 33'd524288;
      11: a = 33'd262144;
      12: a = 33'd131072;
      13: a = 33'd65536;
      14: a = 33'd32768;
      15: a = 33'd16384;
      16: a = 33'd8192;
      17: a = 33'd4096;
      18: a = 33'd2048;
      19: a = 33'd1024;
      20: a = 33'd512;
      21: a = 33'd256;
      22: a = 33'd128;
      23: a = 33'd64;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* sv/gta_sqrt.sv */
// Pipelined digit-by-digit square root: floor(sqrt(m * 2^32)), one result bit per stage.
`timescale 1ns / 1ps
module gta_sqrt
  import gta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_m,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_root,
  output side_t       out_side
);

  localparam int NS = 32;

  logic        vld_r  [0:NS];
  logic [31:0] m_r    [0:NS];
  logic [31:0] root_r [0:NS];
  logic [32:0] rem_r  [0:NS];
  side_t       side_r [0:NS];

  // Stage zero is the input itself
  always_comb begin
    vld_r[0]  = in_valid;
    m_r[0]    = in_m;
    root_r[0] = '0;
    rem_r[0]  = '0;
    side_r[0] = in_side;
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int K = NS - 1 - s;
    logic [1:0]  pair;
    logic [34:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    // Next two bits of m * 2^32; the low half is all zero
    if (K >= 16) begin : g_hi
      assign pair = m_r[s][2*(K-16) +: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_r[s], pair};
    assign trial  = {root_r[s], 2'b01};
    assign ge     = rem_sh >= {1'b0, trial};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    // Keep or subtract the trial value and shift in the new root bit
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[s+1]    <= m_r[s];
        side_r[s+1] <= side_r[s];
        root_r[s+1] <= {root_r[s][30:0], ge};
        rem_r[s+1]  <= ge ? 33'(rem_sh - {1'b0, trial}) : rem_sh[32:0];
      end
    end
  end

  assign out_valid = vld_r[NS];
  assign out_root  = root_r[NS];
  assign out_side  = side_r[NS];

endmodule

/* sv/gta_cordic.sv */
// Pipelined CORDIC vectoring: angle of (u*2^16, r) in Q29 radians, one step per stage.
`timescale 1ns / 1ps
module gta_cordic
  import gta_pkg::*;
#(
  parameter int CORDIC_STEPS = GTA_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          in_root,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z,
  output side_t                out_side
);

  localparam int NS = (CORDIC_STEPS < GTA_ATAN_ENTRIES) ? CORDIC_STEPS : GTA_ATAN_ENTRIES;

  logic                 vld_r  [0:NS];
  logic signed [XW-1:0] x_r    [0:NS];
  logic signed [XW-1:0] y_r    [0:NS];
  logic signed [ZW-1:0] z_r    [0:NS];
  side_t                side_r [0:NS];

  logic signed [XW-1:0] ux;
  logic signed [XW-1:0] rx;

  assign ux = {{(XW-33){in_side.u[16]}}, in_side.u, 16'd0};
  assign rx = {{(XW-32){1'b0}}, in_root};

  // Pre-rotate by -90 degrees when the reference component is negative
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      if (in_side.u < 0) begin
        x_r[0] <= rx;
        y_r[0] <= -ux;
        z_r[0] <= HALF_PI_Q29;
      end else begin
        x_r[0] <= ux;
        y_r[0] <= rx;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign da = atan_q29(i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + da;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - da;
        end
      end
    end
  end

  assign out_valid = vld_r[NS];
  assign out_z     = z_r[NS];
  assign out_side  = side_r[NS];

endmodule

/* sv/gta_scale.sv */
// Unit conversion, half-circle clamp and wrap of the angle; last stage is the output register.
`timescale 1ns / 1ps
module gta_scale
  import gta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 out_deg,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] in_z,
  input  side_t                in_side,
  output logic                 out_valid,
  output out_t                 out_data
);

  logic        a_vld_r;
  logic [59:0] prod_r;
  logic [15:0] rad_r;
  logic        deg_r;
  logic        neg_r;
  logic        zero_r;
  logic [30:0] zc;
  logic [31:0] rad_sum;

  logic        vld_r;
  out_t        data_r;
  logic [60:0] p_rnd;
  logic [15:0] res;
  logic [15:0] half;
  logic [15:0] full;
  logic [15:0] res_c;
  out_t        data_nxt;

  // Clamp z to [0, pi]
  always_comb begin
    if (in_z < 0) begin
      zc = '0;
    end else if (in_z > PI_Q29) begin
      zc = PI_Q29[30:0];
    end else begin
      zc = in_z[30:0];
    end
  end

  assign rad_sum = {1'b0, zc} + 32'd32768;

  // Stage A: scale to degrees by multiplication, to radians by rounding shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 60'(zc * DEG128_MUL);
      rad_r  <= rad_sum[31:16];
      deg_r  <= out_deg;
      neg_r  <= in_side.neg;
      zero_r <= in_side.zero;
    end
  end

  // Stage B: round, clamp to half a circle, mirror when the signing axis is negative
  always_comb begin
    p_rnd = {1'b0, prod_r} + (61'd1 << 44);
    if (deg_r) begin
      res  = 16'(p_rnd[60:45]);
      half = DEG128_HALF;
      full = DEG128_FULL;
    end else begin
      res  = rad_r;
      half = RAD13_HALF;
      full = RAD13_FULL;
    end
    res_c = (res > half) ? half : res;
    if (neg_r && res_c != 16'd0) begin
      res_c = full - res_c;
    end
    if (zero_r) begin
      data_nxt.angle       = '0;
      data_nxt.zero_vector = 1'b1;
    end else begin
      data_nxt.angle       = res_c;
      data_nxt.zero_vector = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

/* sv/gravity_tilt_angle.sv */
// Top level of the gravity tilt angle pipeline.
`timescale 1ns / 1ps
// Gravity tilt angle: takes one raw three-axis accelerometer request per cycle
// while not stalled and returns the angle of gravity from the selected reference
// axis, in 1/128 degree or Q3.13 radians. The pipeline accepts a new request
// every cycle unless it is stalled; it is 2 input stages + 32 square root stages
// (one root bit each) + 1 pre-rotation stage + CORDIC_STEPS CORDIC stages (at
// most 24) + 2 scaling stages. All stages advance together: when the result
// in the output register is not taken, the whole pipeline holds and in_ready
// drops. Configuration writes take effect at once and belong between requests,
// with the pipeline drained.
module gravity_tilt_angle
  import gta_pkg::*;
#(
  parameter int CORDIC_STEPS = GTA_CORDIC_STEPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic cfg_wdata
);

`include "gravity_tilt_angle_macros.svh"

  logic        en;
  logic        cfg_deg_r;
  logic        cfg_axis_r;

  logic        s0_vld_r;
  logic [31:0] vsq_r;
  logic [31:0] wsq_r;
  side_t       s0_side_r;
  logic        s1_vld_r;
  logic [31:0] m_r;
  side_t       s1_side_r;

  logic signed [15:0] v;
  logic signed [15:0] w;
  side_t              side_nxt;

  logic                 sq_vld;
  logic [31:0]          sq_root;
  side_t                sq_side;
  logic                 co_vld;
  logic signed [ZW-1:0] co_z;
  side_t                co_side;

  // Advance everything unless the output holds an untaken result
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_deg_r  <= 1'b1;
      cfg_axis_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OUT_DEG:  cfg_deg_r  <= cfg_wdata;
        REG_REF_AXIS: cfg_axis_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pick reference and signing axes
  always_comb begin
    if (cfg_axis_r == 1'b0) begin
      side_nxt.u   = -{in_data.accel_x[15], in_data.accel_x};
      side_nxt.neg = in_data.accel_y[15];
      v            = in_data.accel_y;
    end else begin
      side_nxt.u   = {in_data.accel_y[15], in_data.accel_y};
      side_nxt.neg = in_data.accel_x[15];
      v            = in_data.accel_x;
    end
    w             = in_data.accel_z;
    side_nxt.zero = (in_data.accel_x == 0) && (in_data.accel_y == 0) &&
                    (in_data.accel_z == 0);
  end

  // Stage 0: square the two side components
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vsq_r     <= 32'(v * v);
      wsq_r     <= 32'(w * w);
      s0_side_r <= side_nxt;
      // Stage 1: sum of squares
      m_r       <= vsq_r + wsq_r;
      s1_side_r <= s0_side_r;
    end
  end

  gta_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_vld_r),
    .in_m      (m_r),
    .in_side   (s1_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  gta_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_vld),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (co_vld),
    .out_z     (co_z),
    .out_side  (co_side)
  );

  gta_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .out_deg   (cfg_deg_r),
    .in_valid  (co_vld),
    .in_z      (co_z),
    .in_side   (co_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Checks
  `GTA_ASSERT_IMP(a_zero_angle, out_valid && out_data.zero_vector,
                  out_data.angle == 16'd0, "zero vector with nonzero angle")
  `GTA_ASSERT_IMP(a_angle_range, out_valid,
                  (cfg_deg_r && out_data.angle < DEG128_FULL) ||
                  (!cfg_deg_r && out_data.angle < RAD13_FULL),
                  "angle not below full circle")
  `GTA_ASSERT_NEXT(a_cfg_deg, cfg_we && cfg_idx == REG_OUT_DEG,
                   cfg_deg_r == $past(cfg_wdata), "unit register not written")

endmodule

/* sim/gravity_tilt_angle_tb.sv */
// Testbench for the gravity tilt angle pipeline: directed and random requests.
`timescale 1ns / 1ps
module gravity_tilt_angle_tb;
  import gta_pkg::*;

  localparam int LATENCY = 53;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [63:0] PI_Z = 64'd1686629713;
  localparam logic [63:0] HALF_PI_Z = 64'd843314857;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_idx;
  logic cfg_wdata;

  // mirrored register values
  logic use_degrees;
  logic ref_axis;

  out_t angle_q[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  int errors;
  int n_sent;
  int n_checked;
  longint cycle_count;

  gravity_tilt_angle i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floor.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_step(input int i);
    case (i)
      0: return 421657428;   1: return 248918915;   2: return 131521918;
      3: return 66762579;    4: return 33510843;    5: return 16771758;
      6: return 8387925;     7: return 4194219;     8: return 2097141;
      9: return 1048575;     10: return 524288;     11: return 262144;
      12: return 131072;     13: return 65536;      14: return 32768;
      15: return 16384;      16: return 8192;       17: return 4096;
      18: return 2048;       19: return 1024;       20: return 512;
      21: return 256;        22: return 128;        23: return 64;
      default: return 0;
    endcase
  endfunction

  // Compute the expected tilt angle of one request.
  function automatic out_t tilt_angle(input in_t s);
    out_t o;
    longint u, v, w, x, y, z, dx, dy, t;
    logic neg;
    logic [63:0] m, r, p;
    logic [31:0] res, half, full;
    o = '0;
    if (s.accel_x == 0 && s.accel_y == 0 && s.accel_z == 0) begin
      o.zero_vector = 1'b1;
      return o;
    end
    if (!ref_axis) begin
      u = -longint'(s.accel_x); v = s.accel_y; w = s.accel_z; neg = s.accel_y < 0;
    end else begin
      u = s.accel_y; v = s.accel_x; w = s.accel_z; neg = s.accel_x < 0;
    end
    m = v * v + w * w;
    r = int_sqrt(m << 32);
    x = u * 65536;
    y = longint'(r);
    z = 0;
    if (u < 0) begin
      t = x; x = y; y = -t; z = longint'(HALF_PI_Z);
    end
    for (int i = 0; i < GTA_CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(PI_Z)) z = longint'(PI_Z);
    if (use_degrees) begin
      p = 64'(z) * 64'd480631834 + (64'd1 << 44);
      res = 32'(p >> 45);
      half = 32'(DEG128_HALF); full = 32'(DEG128_FULL);
    end else begin
      res = 32'((64'(z) + 64'd32768) >> 16);
      half = 32'(RAD13_HALF); full = 32'(RAD13_FULL);
    end
    if (res > half) res = half;
    if (neg && res != 0) res = full - res;
    o.angle = res[15:0];
    return o;
  endfunction

  // Send one request; idle at random first, hold valid until accepted.
  task automatic send_sample(input in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angle_q.push_back(tilt_angle(s));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    in_t s;
    s.accel_x = 16'(x); s.accel_y = 16'(y); s.accel_z = 16'(z);
    send_sample(s);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic drain;
    in_valid <= 1'b0;
    while (angle_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Write one register while the pipeline is empty.
  task automatic write_reg(input logic idx, input logic val);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OUT_DEG) use_degrees = val;
    else ref_axis = val;
  endtask

  task automatic set_mode(input logic deg, input logic axis);
    write_reg(REG_OUT_DEG, deg);
    write_reg(REG_REF_AXIS, axis);
  endtask

  // Random sample: mostly full range, some small, some on an axis, some all zero.
  function automatic in_t rand_sample();
    in_t s;
    int kind;
    kind = $urandom_range(9);
    s.accel_x = 16'($urandom); s.accel_y = 16'($urandom); s.accel_z = 16'($urandom);
    if (kind == 0) begin
      s.accel_x = 16'($urandom_range(4) - 2);
      s.accel_y = 16'($urandom_range(4) - 2);
      s.accel_z = 16'($urandom_range(4) - 2);
    end else if (kind == 1) begin
      s.accel_y = 0; s.accel_z = 0;
    end else if (kind == 2) begin
      s.accel_x = 0; s.accel_z = 0;
    end else if (kind == 3) begin
      s.accel_x = 0; s.accel_y = 0; s.accel_z = 0;
    end
    return s;
  endfunction

  task automatic test_directed;
    set_mode(1'b1, 1'b0);
    send_xyz(0, 0, 0);
    send_xyz(-16384, 0, 0);
    send_xyz(16384, 0, 0);
    send_xyz(-32768, -32768, -32768);
    send_xyz(32767, 32767, 32767);
    send_xyz(0, 1, 0);
    send_xyz(0, -1, 0);
    send_xyz(0, 0, -32768);
    send_xyz(-100, -1, 0);
    send_xyz(1, 0, 0);
    send_xyz(-1, 0, 0);
    send_xyz(-32768, 0, 0);
    set_mode(1'b0, 1'b1);
    send_xyz(0, 0, 0);
    send_xyz(0, 16384, 0);
    send_xyz(0, -16384, 0);
    send_xyz(-1, 32767, 0);
    send_xyz(32767, -32768, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(0, -32768, 0);
    send_xyz(-5, 0, 7);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_sample(rand_sample());
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off long enough to fill the pipeline and stall input.
  task automatic test_backpressure;
    hold_off = 200;
    repeat (150) send_sample(rand_sample());
    in_valid <= 1'b0;
    while (hold_off != 0) @(negedge clk);
    drain();
  endtask

  task automatic test_mode_sweep;
    for (int m = 0; m < 4; m++) begin
      set_mode(m[0], m[1]);
      test_random(100, 0, 0);
      test_random(100, 74, 0);
      test_random(100, 0, 74);
      test_random(100, 11, 11);
    end
  endtask

  // Receiver: random stalls plus a counted hold-off.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (angle_q.size() == 0) begin
        $error("unexpected result: angle %0d zero_vector %0d",
               out_data.angle, out_data.zero_vector);
        errors++;
      end else begin
        out_t exp_o;
        exp_o = angle_q.pop_front();
        if (out_data.angle !== exp_o.angle) begin
          $error("angle: expected %0d, actual %0d", exp_o.angle, out_data.angle);
          errors++;
        end
        if (out_data.zero_vector !== exp_o.zero_vector) begin
          $error("zero_vector: expected %0d, actual %0d",
                 exp_o.zero_vector, out_data.zero_vector);
          errors++;
        end
        n_checked++;
      end
    end
  end

  // Abort on a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL gravity_tilt_angle");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = 1'b0;
    cfg_wdata = 1'b0;
    use_degrees = 1'b1;
    ref_axis = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    cycle_count = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_mode_sweep();
    set_mode(1'b1, 1'b0);
    test_random(160, 30, 30);
    drain();
    if (angle_q.size() != 0) begin
      $error("%0d expected results never arrived", angle_q.size());
      errors++;
    end
    $display("covered %0d requests, %0d results checked, both units and both axes",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("PASS gravity_tilt_angle");
    end else begin
      $display("FAIL gravity_tilt_angle");
    end
    $finish;
  end
endmodule
